>>> sv/shk_pkg.sv
// Package for the IMU shake detector: register map codes, reset values,
// default parameter values and the structs shared between modules.
// No dependencies.
package shk_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;
    localparam int TALLY_W   = 8;

    localparam logic [REG_IDX_W-1:0] REG_ACCEL_TRIG = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GYRO_TRIG  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_REL  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GYRO_REL   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COOLDOWN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PEAK_GAP   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PEAKS_NEED = 3'd7;

    localparam logic [31:0]        ACCEL_TRIG_RST = 32'd16777216;
    localparam logic [31:0]        GYRO_TRIG_RST  = 32'd1048576000;
    localparam logic [31:0]        ACCEL_REL_RST  = 32'd5242880;
    localparam logic [31:0]        GYRO_REL_RST   = 32'd104857600;
    localparam logic [15:0]        COOLDOWN_RST   = 16'd1000;
    localparam logic [15:0]        WINDOW_RST     = 16'd800;
    localparam logic [15:0]        PEAK_GAP_RST   = 16'd80;
    localparam logic [TALLY_W-1:0] PEAKS_NEED_RST = 8'd2;

    typedef struct packed {
        logic [31:0]        accel_trigger_sq;
        logic [31:0]        gyro_trigger_sq;
        logic [31:0]        accel_release_sq;
        logic [31:0]        gyro_release_sq;
        logic [15:0]        cooldown_ms;
        logic [15:0]        window_ms;
        logic [15:0]        peak_gap_ms;
        logic [TALLY_W-1:0] peaks_needed;
    } cfg_t;

    typedef struct packed {
        logic               armed;
        logic               cand_open;
        logic               shake_seen;
        logic [TALLY_W-1:0] tally;
    } track_status_t;

endpackage

>>> sv/shk_cfg_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on shk_pkg for the register map, reset values and cfg_t.
module shk_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [shk_pkg::ADDR_W-1:0] paddr,
    input  logic [shk_pkg::DATA_W-1:0] pwdata,
    output logic [shk_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output shk_pkg::cfg_t              cfg
);

    shk_pkg::cfg_t                  cfg_reg;
    logic [shk_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[shk_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_trigger_sq <= shk_pkg::ACCEL_TRIG_RST;
            cfg_reg.gyro_trigger_sq  <= shk_pkg::GYRO_TRIG_RST;
            cfg_reg.accel_release_sq <= shk_pkg::ACCEL_REL_RST;
            cfg_reg.gyro_release_sq  <= shk_pkg::GYRO_REL_RST;
            cfg_reg.cooldown_ms      <= shk_pkg::COOLDOWN_RST;
            cfg_reg.window_ms        <= shk_pkg::WINDOW_RST;
            cfg_reg.peak_gap_ms      <= shk_pkg::PEAK_GAP_RST;
            cfg_reg.peaks_needed     <= shk_pkg::PEAKS_NEED_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                shk_pkg::REG_ACCEL_TRIG: cfg_reg.accel_trigger_sq <= pwdata;
                shk_pkg::REG_GYRO_TRIG:  cfg_reg.gyro_trigger_sq  <= pwdata;
                shk_pkg::REG_ACCEL_REL:  cfg_reg.accel_release_sq <= pwdata;
                shk_pkg::REG_GYRO_REL:   cfg_reg.gyro_release_sq  <= pwdata;
                shk_pkg::REG_COOLDOWN:   cfg_reg.cooldown_ms      <= pwdata[15:0];
                shk_pkg::REG_WINDOW:     cfg_reg.window_ms        <= pwdata[15:0];
                shk_pkg::REG_PEAK_GAP:   cfg_reg.peak_gap_ms      <= pwdata[15:0];
                shk_pkg::REG_PEAKS_NEED:
                    cfg_reg.peaks_needed <= pwdata[shk_pkg::TALLY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            shk_pkg::REG_ACCEL_TRIG: prdata = cfg_reg.accel_trigger_sq;
            shk_pkg::REG_GYRO_TRIG:  prdata = cfg_reg.gyro_trigger_sq;
            shk_pkg::REG_ACCEL_REL:  prdata = cfg_reg.accel_release_sq;
            shk_pkg::REG_GYRO_REL:   prdata = cfg_reg.gyro_release_sq;
            shk_pkg::REG_COOLDOWN:   prdata = {16'd0, cfg_reg.cooldown_ms};
            shk_pkg::REG_WINDOW:     prdata = {16'd0, cfg_reg.window_ms};
            shk_pkg::REG_PEAK_GAP:   prdata = {16'd0, cfg_reg.peak_gap_ms};
            shk_pkg::REG_PEAKS_NEED: prdata = {24'd0, cfg_reg.peaks_needed};
            default:                 prdata = '0;
        endcase
    end

endmodule

>>> sv/shk_energy.sv
// Input register and squared-magnitude stage: squares each axis and sums
// the accel and gyro vectors into registered energies. Depends on shk_pkg.
module shk_energy #(
    parameter int SAMPLE_BITS = shk_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = shk_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] accel_x,
    input  logic signed [SAMPLE_BITS-1:0] accel_y,
    input  logic signed [SAMPLE_BITS-1:0] accel_z,
    input  logic signed [SAMPLE_BITS-1:0] gyro_x,
    input  logic signed [SAMPLE_BITS-1:0] gyro_y,
    input  logic signed [SAMPLE_BITS-1:0] gyro_z,
    input  logic [TIME_BITS-1:0]          now,
    output logic                          sum_valid,
    output logic [2*SAMPLE_BITS-1:0]      acc_sum,
    output logic [2*SAMPLE_BITS-1:0]      gyr_sum,
    output logic [TIME_BITS-1:0]          sum_time
);

    localparam int SQ_W = 2 * SAMPLE_BITS;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] ax_reg, ay_reg, az_reg;
    logic signed [SAMPLE_BITS-1:0] gx_reg, gy_reg, gz_reg;
    logic [TIME_BITS-1:0]          in_time_reg;

    logic signed [SQ_W-1:0] ax_sq, ay_sq, az_sq, gx_sq, gy_sq, gz_sq;
    logic [SQ_W-1:0]        acc_next, gyr_next;

    logic                   sum_valid_reg;
    logic [SQ_W-1:0]        acc_reg, gyr_reg;
    logic [TIME_BITS-1:0]   sum_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= in_valid;
            sum_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax_reg       <= accel_x;
            ay_reg       <= accel_y;
            az_reg       <= accel_z;
            gx_reg       <= gyro_x;
            gy_reg       <= gyro_y;
            gz_reg       <= gyro_z;
            in_time_reg  <= now;
            acc_reg      <= acc_next;
            gyr_reg      <= gyr_next;
            sum_time_reg <= in_time_reg;
        end
    end

    // squares of signed values are non-negative and fit in 2*SAMPLE_BITS
    assign ax_sq = SQ_W'(ax_reg) * SQ_W'(ax_reg);
    assign ay_sq = SQ_W'(ay_reg) * SQ_W'(ay_reg);
    assign az_sq = SQ_W'(az_reg) * SQ_W'(az_reg);
    assign gx_sq = SQ_W'(gx_reg) * SQ_W'(gx_reg);
    assign gy_sq = SQ_W'(gy_reg) * SQ_W'(gy_reg);
    assign gz_sq = SQ_W'(gz_reg) * SQ_W'(gz_reg);

    assign acc_next = $unsigned(ax_sq) + $unsigned(ay_sq) + $unsigned(az_sq);
    assign gyr_next = $unsigned(gx_sq) + $unsigned(gy_sq) + $unsigned(gz_sq);

    assign sum_valid = sum_valid_reg;
    assign acc_sum   = acc_reg;
    assign gyr_sum   = gyr_reg;
    assign sum_time  = sum_time_reg;

endmodule

>>> sv/shk_track.sv
// Peak tracking and shake decision stage: threshold compares, arming,
// peak spacing, window and cooldown, plus the result register. Depends on shk_pkg.
module shk_track #(
    parameter int SAMPLE_BITS = shk_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = shk_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          sum_valid,
    input  logic [2*SAMPLE_BITS-1:0]      acc_sum,
    input  logic [2*SAMPLE_BITS-1:0]      gyr_sum,
    input  logic [TIME_BITS-1:0]          now,
    input  shk_pkg::cfg_t                 cfg,
    output logic                          out_valid,
    output logic                          shake_detected,
    output shk_pkg::track_status_t        status
);

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int CMP_W = (SQ_W > 32) ? SQ_W : 32;
    localparam int TW    = shk_pkg::TALLY_W;

    logic                 armed_reg, armed_next;
    logic                 cand_open_reg, cand_open_next;
    logic [TW-1:0]        tally_reg, tally_next;
    logic [TIME_BITS-1:0] cand_start_reg, cand_start_next;
    logic                 peak_seen_reg, peak_seen_next;
    logic [TIME_BITS-1:0] last_peak_reg, last_peak_next;
    logic                 shake_seen_reg, shake_seen_next;
    logic [TIME_BITS-1:0] last_shake_reg, last_shake_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 shake_reg, shake_next;

    logic [CMP_W-1:0]     acc_w, gyr_w;
    logic                 above, below;
    logic [TIME_BITS-1:0] since_shake, since_start, since_peak;
    logic                 in_cooldown, expired, spaced;
    logic                 open_live, armed_live;
    logic [TW-1:0]        tally_live, tally_inc, need;
    logic                 fire;

    assign acc_w = CMP_W'(acc_sum);
    assign gyr_w = CMP_W'(gyr_sum);
    assign above = (acc_w >= CMP_W'(cfg.accel_trigger_sq))
                || (gyr_w >= CMP_W'(cfg.gyro_trigger_sq));
    assign below = (acc_w <= CMP_W'(cfg.accel_release_sq))
                && (gyr_w <= CMP_W'(cfg.gyro_release_sq));

    assign since_shake = now - last_shake_reg;
    assign since_start = now - cand_start_reg;
    assign since_peak  = now - last_peak_reg;

    assign in_cooldown = shake_seen_reg && (since_shake < TIME_BITS'(cfg.cooldown_ms));
    assign expired     = cand_open_reg && (since_start > TIME_BITS'(cfg.window_ms));
    assign spaced      = !peak_seen_reg || (since_peak >= TIME_BITS'(cfg.peak_gap_ms));
    assign need        = (cfg.peaks_needed == '0) ? TW'(1) : cfg.peaks_needed;

    assign open_live  = cand_open_reg && !expired;
    assign armed_live = armed_reg || below;
    assign tally_live = open_live ? tally_reg : '0;
    assign tally_inc  = tally_live + TW'(1);
    assign fire       = above && armed_live && spaced;

    always_comb
    begin
        armed_next      = armed_reg;
        cand_open_next  = cand_open_reg;
        tally_next      = tally_reg;
        cand_start_next = cand_start_reg;
        peak_seen_next  = peak_seen_reg;
        last_peak_next  = last_peak_reg;
        shake_seen_next = shake_seen_reg;
        last_shake_next = last_shake_reg;
        shake_next      = 1'b0;

        if (in_cooldown)
        begin
            armed_next     = armed_live;
            cand_open_next = 1'b0;
            tally_next     = '0;
        end
        else
        begin
            armed_next     = armed_live;
            cand_open_next = open_live;
            tally_next     = tally_live;
            if (fire)
            begin
                if (!open_live)
                begin
                    cand_start_next = now;
                end
                last_peak_next = now;
                peak_seen_next = 1'b1;
                armed_next     = 1'b0;
                if (tally_inc >= need)
                begin
                    shake_seen_next = 1'b1;
                    last_shake_next = now;
                    cand_open_next  = 1'b0;
                    tally_next      = '0;
                    shake_next      = 1'b1;
                end
                else
                begin
                    cand_open_next = 1'b1;
                    tally_next     = tally_inc;
                end
            end
        end
    end

    assign out_valid_next = advance ? sum_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b1;
            cand_open_reg  <= 1'b0;
            tally_reg      <= '0;
            cand_start_reg <= '0;
            peak_seen_reg  <= 1'b0;
            last_peak_reg  <= '0;
            shake_seen_reg <= 1'b0;
            last_shake_reg <= '0;
            out_valid_reg  <= 1'b0;
            shake_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance && sum_valid)
            begin
                armed_reg      <= armed_next;
                cand_open_reg  <= cand_open_next;
                tally_reg      <= tally_next;
                cand_start_reg <= cand_start_next;
                peak_seen_reg  <= peak_seen_next;
                last_peak_reg  <= last_peak_next;
                shake_seen_reg <= shake_seen_next;
                last_shake_reg <= last_shake_next;
                shake_reg      <= shake_next;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign shake_detected    = shake_reg;
    assign status.armed      = armed_reg;
    assign status.cand_open  = cand_open_reg;
    assign status.shake_seen = shake_seen_reg;
    assign status.tally      = tally_reg;

endmodule

>>> sv/imu_shake_detector_unit.sv
// Top level of the IMU shake detector: valid/ready sample and result
// channels, APB configuration port. Depends on shk_pkg, shk_cfg_regs,
// shk_energy and shk_track.
//
// Accepts one sample word per clock while in_ready is high and returns one
// result word per sample. A sample passes through an input register, a
// registered square-and-sum stage for the accel and gyro vectors, and a
// decision stage that updates the peak/window/cooldown state and loads
// the result register, which drives out_valid. The whole
// pipeline holds while a result waits to be taken, so sustained throughput
// is one word per cycle whenever out_ready is high.
// Configuration registers sit at byte addresses 4*i and should be written
// only while no sample is in flight.
module imu_shake_detector_unit #(
    parameter int SAMPLE_BITS = shk_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = shk_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] accel_x,
    input  logic signed [SAMPLE_BITS-1:0] accel_y,
    input  logic signed [SAMPLE_BITS-1:0] accel_z,
    input  logic signed [SAMPLE_BITS-1:0] gyro_x,
    input  logic signed [SAMPLE_BITS-1:0] gyro_y,
    input  logic signed [SAMPLE_BITS-1:0] gyro_z,
    input  logic [31:0]                   time_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          shake_detected,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shk_pkg::ADDR_W-1:0]    paddr,
    input  logic [shk_pkg::DATA_W-1:0]    pwdata,
    output logic [shk_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    shk_pkg::cfg_t              cfg;
    shk_pkg::track_status_t     status;
    logic                       advance;
    logic                       sum_valid;
    logic [2*SAMPLE_BITS-1:0]   acc_sum, gyr_sum;
    logic [TIME_BITS-1:0]       sum_time;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    shk_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shk_energy #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_energy (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .gyro_x    (gyro_x),
        .gyro_y    (gyro_y),
        .gyro_z    (gyro_z),
        .now       (time_ms[TIME_BITS-1:0]),
        .sum_valid (sum_valid),
        .acc_sum   (acc_sum),
        .gyr_sum   (gyr_sum),
        .sum_time  (sum_time)
    );

    shk_track #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .sum_valid      (sum_valid),
        .acc_sum        (acc_sum),
        .gyr_sum        (gyr_sum),
        .now            (sum_time),
        .cfg            (cfg),
        .out_valid      (out_valid),
        .shake_detected (shake_detected),
        .status         (status)
    );

    a_open_tally: assert property (@(posedge clk) disable iff (!rst_n)
        status.cand_open == (status.tally != '0))
        else $error("candidate flag and peak tally disagree");

    a_shake_marks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && shake_detected |-> status.shake_seen && !status.cand_open)
        else $error("shake reported without shake state");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && advance |=> out_valid)
        else $error("decision stage dropped a word");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for imu_shake_detector_unit: streams IMU sample words, programs the
// thresholds over APB and checks each shake_detected word against its own predictor.
// Depends on shk_pkg and the imu_shake_detector_unit RTL.
module tb;
    import shk_pkg::*;

    typedef struct packed {
        logic [5:0][15:0] axis;
        logic [31:0]      t;
    } sample_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] accel_x = '0;
    logic signed [15:0] accel_y = '0;
    logic signed [15:0] accel_z = '0;
    logic signed [15:0] gyro_x = '0;
    logic signed [15:0] gyro_y = '0;
    logic signed [15:0] gyro_z = '0;
    logic [31:0]        time_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               shake_detected;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    cfg_t cfg = {ACCEL_TRIG_RST, GYRO_TRIG_RST, ACCEL_REL_RST, GYRO_REL_RST,
                 COOLDOWN_RST, WINDOW_RST, PEAK_GAP_RST, PEAKS_NEED_RST};

    logic        armed = 1'b1;
    logic        cand_open = 1'b0;
    logic [7:0]  tally = '0;
    logic [31:0] cand_start_ms = '0;
    logic        peak_seen = 1'b0;
    logic [31:0] last_peak_ms = '0;
    logic        shake_seen = 1'b0;
    logic [31:0] last_shake_ms = '0;

    sample_t     pending_samples[$];
    logic        due_shake_q[$];
    logic [31:0] stamp_ms = '0;
    int          mismatches = 0;
    int          words_in = 0;
    int          send_idle_pct = 7;
    int          recv_idle_pct = 7;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    imu_shake_detector_unit DUT (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] axis_sq(logic signed [15:0] v);
        longint w;
        w = v;
        return w * w;
    endfunction

    function automatic logic shake_after_sample(sample_t s);
        logic [63:0] acc_sq;
        logic [63:0] gyr_sq;
        logic [7:0]  need;
        logic        above;
        logic        below;
        logic        fired;
        fired  = 1'b0;
        acc_sq = axis_sq(s.axis[0]) + axis_sq(s.axis[1]) + axis_sq(s.axis[2]);
        gyr_sq = axis_sq(s.axis[3]) + axis_sq(s.axis[4]) + axis_sq(s.axis[5]);
        need   = (cfg.peaks_needed == '0) ? 8'd1 : cfg.peaks_needed;
        above  = acc_sq >= 64'(cfg.accel_trigger_sq) || gyr_sq >= 64'(cfg.gyro_trigger_sq);
        below  = acc_sq <= 64'(cfg.accel_release_sq) && gyr_sq <= 64'(cfg.gyro_release_sq);
        if (shake_seen && 32'(s.t - last_shake_ms) < 32'(cfg.cooldown_ms))
        begin
            if (below)
                armed = 1'b1;
            cand_open = 1'b0;
            tally     = '0;
        end
        else
        begin
            if (cand_open && 32'(s.t - cand_start_ms) > 32'(cfg.window_ms))
            begin
                cand_open = 1'b0;
                tally     = '0;
            end
            if (below)
                armed = 1'b1;
            if (above && armed &&
                (!peak_seen || 32'(s.t - last_peak_ms) >= 32'(cfg.peak_gap_ms)))
            begin
                if (!cand_open)
                begin
                    cand_open     = 1'b1;
                    cand_start_ms = s.t;
                    tally         = '0;
                end
                tally        = tally + 8'd1;
                last_peak_ms = s.t;
                peak_seen    = 1'b1;
                armed        = 1'b0;
                if (tally >= need)
                begin
                    shake_seen    = 1'b1;
                    last_shake_ms = s.t;
                    cand_open     = 1'b0;
                    tally         = '0;
                    fired         = 1'b1;
                end
            end
        end
        return fired;
    endfunction

    function automatic logic [15:0] any_axis();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] big_axis(int unsigned lo);
        logic [15:0] m;
        m = 16'($urandom_range(lo, 32768));
        return ($urandom_range(0, 1) != 0) ? ~m + 16'd1 : m;
    endfunction

    function automatic sample_t quiet_sample();
        sample_t s;
        s = '0;
        if ($urandom_range(0, 3) != 0)
            for (int k = 0; k < 6; k++)
                s.axis[k] = 16'($urandom_range(0, 600) - 300);
        return s;
    endfunction

    function automatic sample_t loud_sample();
        sample_t     s;
        int unsigned pick;
        s    = quiet_sample();
        pick = $urandom_range(0, 99);
        if (pick < 8)
            s.axis[2:0] = {3{16'h8000}};
        else if (pick < 16)
            s.axis[5:3] = {3{16'h8000}};
        else if (pick < 65)
            s.axis[$urandom_range(0, 2)] = big_axis(4096);
        else
            s.axis[$urandom_range(3, 5)] = big_axis(20000);
        return s;
    endfunction

    function automatic sample_t noise_sample();
        sample_t s;
        s = '0;
        for (int k = 0; k < 6; k++)
            s.axis[k] = any_axis();
        return s;
    endfunction

    function automatic logic [31:0] noise_step();
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'($urandom_range(0, 20));
            3, 4:    return 32'($urandom_range(0, 32'(cfg.window_ms) + 4));
            5, 6:    return 32'($urandom_range(0, 32'(cfg.cooldown_ms) + 4));
            7, 8:    return 32'($urandom_range(0, 4000));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] peak_step();
        int d;
        d = int'(cfg.peak_gap_ms) + int'($urandom_range(0, 6)) - 3;
        if (cfg.peaks_needed <= 8 && $urandom_range(0, 9) == 0)
            d = d + int'(cfg.window_ms) / 2;
        return (d < 0) ? 32'd0 : 32'(d);
    endfunction

    task automatic queue_sample(sample_t s, logic [31:0] step);
        stamp_ms = stamp_ms + step;
        s.t      = stamp_ms;
        pending_samples.push_back(s);
    endtask

    task automatic push_axes(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                             logic [31:0] t);
        sample_t s;
        s.axis   = {gz, gy, gx, az, ay, ax};
        s.t      = t;
        stamp_ms = t;
        pending_samples.push_back(s);
    endtask

    // bursts of peaks spaced around the gap, mixed with stretches of noise
    task automatic add_traffic(int n);
        int left;
        int peaks;
        int quiet_pct;
        left      = n;
        quiet_pct = (cfg.peaks_needed > 8) ? 10 : 60;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                peaks = int'(cfg.peaks_needed) + int'($urandom_range(0, 2)) - 1;
                if (peaks < 1)
                    peaks = 1;
                for (int k = 0; k < peaks && left > 0; k++)
                begin
                    queue_sample(loud_sample(), peak_step());
                    left--;
                    if (left > 0 && $urandom_range(0, 99) < quiet_pct)
                    begin
                        queue_sample(quiet_sample(), 32'($urandom_range(0, 10)));
                        left--;
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    if (left > 0)
                    begin
                        queue_sample(noise_sample(), noise_step());
                        left--;
                    end
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || in_valid || due_shake_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ACCEL_TRIG: cfg.accel_trigger_sq = value;
            REG_GYRO_TRIG:  cfg.gyro_trigger_sq  = value;
            REG_ACCEL_REL:  cfg.accel_release_sq = value;
            REG_GYRO_REL:   cfg.gyro_release_sq  = value;
            REG_COOLDOWN:   cfg.cooldown_ms      = value[15:0];
            REG_WINDOW:     cfg.window_ms        = value[15:0];
            REG_PEAK_GAP:   cfg.peak_gap_ms      = value[15:0];
            REG_PEAKS_NEED: cfg.peaks_needed     = value[7:0];
            default: ;
        endcase
    endtask

    task automatic program_config(logic [31:0] acc_trig, logic [31:0] gyr_trig,
                                  logic [31:0] acc_rel, logic [31:0] gyr_rel,
                                  logic [15:0] cooldown, logic [15:0] window,
                                  logic [15:0] gap, logic [7:0] need);
        write_reg(REG_ACCEL_TRIG, acc_trig);
        write_reg(REG_GYRO_TRIG, gyr_trig);
        write_reg(REG_ACCEL_REL, acc_rel);
        write_reg(REG_GYRO_REL, gyr_rel);
        write_reg(REG_COOLDOWN, 32'(cooldown));
        write_reg(REG_WINDOW, 32'(window));
        write_reg(REG_PEAK_GAP, 32'(gap));
        write_reg(REG_PEAKS_NEED, 32'(need));
    endtask

    always @(posedge clk)
    begin : drive_samples
        sample_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = pending_samples.pop_front();
                accel_x  <= nxt.axis[0];
                accel_y  <= nxt.axis[1];
                accel_z  <= nxt.axis[2];
                gyro_x   <= nxt.axis[3];
                gyro_y   <= nxt.axis[4];
                gyro_z   <= nxt.axis[5];
                time_ms  <= nxt.t;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // hold off once for a long stretch so the pipeline backs up into in_ready
    always @(posedge clk)
    begin : drive_ready
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && words_in >= 300)
        begin
            out_ready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        sample_t got;
        logic    want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                got.axis = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};
                got.t    = time_ms;
                due_shake_q.push_back(shake_after_sample(got));
                words_in <= words_in + 1;
            end
            if (out_valid && out_ready)
            begin
                if (due_shake_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: shake_detected=%0b", shake_detected);
                end
                else
                begin
                    want = due_shake_q.pop_front();
                    if (shake_detected !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("shake_detected mismatch: expected %0b, got %0b",
                                     want, shake_detected);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_axes(0, 0, 0, 0, 0, 0, 32'd0);
        push_axes(16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 32'd5);
        push_axes(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd10);
        push_axes(0, 0, 0, 0, 0, 0, 32'd20);
        push_axes(0, 0, 0, 16'h8000, 0, 0, 32'd60);
        push_axes(16'h8000, 0, 0, 0, 0, 0, 32'd100);
        push_axes(0, 0, 0, 0, 0, 0, 32'd200);
        push_axes(16'd8000, 0, 0, 0, 0, 0, 32'd500);
        push_axes(0, 0, 0, 0, 0, 0, 32'd1099);
        push_axes(0, 16'd8000, 0, 0, 0, 0, 32'd1100);
        push_axes(0, 0, 0, 0, 0, 0, 32'd1150);
        push_axes(0, 0, 16'd8000, 0, 0, 0, 32'd2000);
        push_axes(0, 0, 0, 0, 0, 0, 32'd2050);
        push_axes(-16'sd8000, 0, 0, 0, 0, 0, 32'd2800);
        push_axes(0, 0, 0, 0, 0, 0, 32'hffff_ff00);
        push_axes(16'd8000, 0, 0, 0, 0, 0, 32'hffff_fff0);
        push_axes(0, 0, 0, 0, 0, 0, 32'hffff_fff8);
        push_axes(0, 0, 0, 0, 16'h7fff, 16'h7fff, 32'h0000_0040);
        push_axes(0, 0, 0, 0, 0, 0, 32'h0000_0020);
        push_axes(16'd8000, 0, 0, 0, 0, 0, 32'h0000_0030);
        push_axes(16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000,
                  32'hffff_ffff);
        push_axes(0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 32'h0000_0035);
        wait_idle();

        program_config(32'd9000000, 32'd400000000, 32'd1000000, 32'd2000000,
                       16'd300, 16'd500, 16'd40, 8'd3);
        add_traffic(500);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_config('0, '0, '0, '0, '0, '0, '0, '0);
        add_traffic(150);
        wait_idle();

        program_config(32'd1000000, 32'd1000000, 32'd3221225472, 32'd3221225472,
                       16'd65535, 16'd65535, 16'd0, 8'd255);
        add_traffic(420);
        wait_idle();

        send_idle_pct = 7;
        recv_idle_pct = 7;
        program_config(32'd3221225472, 32'd3221225472, '0, '0,
                       16'd0, 16'd0, 16'd65535, 8'd1);
        add_traffic(120);
        wait_idle();

        program_config(ACCEL_TRIG_RST, GYRO_TRIG_RST, ACCEL_REL_RST, GYRO_REL_RST,
                       COOLDOWN_RST, WINDOW_RST, PEAK_GAP_RST, PEAKS_NEED_RST);
        add_traffic(380);
        wait_idle();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
